[design/csvs_pkg.sv]
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared constants, types, rounding and saturation helpers for the Chebyshev
// series value and slope pipeline.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int MAX_TERMS     = 6;
  localparam int NUM_TERMS_DEF = 6;

  // quotient bits of the two restoring dividers
  localparam int DIV1_QW = 30;
  localparam int DIV2_QW = 33;

  localparam int XW = 31;  // mapped x, Q.28 signed
  localparam int PW = 32;  // polynomial values, Q.28 signed
  localparam int SW = 64;  // accumulators

  localparam logic signed [PW-1:0] ONE_Q28   = 32'sd268435456;
  localparam logic signed [31:0]   START_RST = 32'sd0;
  localparam logic signed [31:0]   END_RST   = 32'sd65536;
  localparam logic signed [31:0]   COEF_RST  = 32'sd0;

  typedef enum logic [2:0] {
    REG_START_TIME,
    REG_END_TIME,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_COEF_5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [PW-1:0] tp;
    logic signed [PW-1:0] tc;
    logic signed [PW-1:0] up;
    logic signed [PW-1:0] uc;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] py;
    logic signed [SW-1:0] d;
    logic                 err;
  } poly_bus_t;

  // input to output, in cycles
  function automatic int pipe_latency(input int n);
    return 2 + DIV1_QW + 3 + 3 * (n - 2) + 1 + DIV2_QW + 1;
  endfunction

  // arithmetic shift right, rounded half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? $signed(~r + 64'd1) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/csvs_div.sv]
// ----------------------------------------------------------------------------
// csvs_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Requires num < den * 2^QW.
// ----------------------------------------------------------------------------
module csvs_div import csvs_pkg::*; #(
  parameter int NW  = 62,
  parameter int DW  = 33,
  parameter int QW  = 30,
  parameter int SBW = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_side,
  output logic           out_vld,
  output logic [QW-1:0]  out_quo,
  output logic [SBW-1:0] out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic           vld_r  [QW];
  logic [CW-1:0]  rem_r  [QW];
  logic [QW-1:0]  quo_r  [QW];
  logic [DW-1:0]  den_r  [QW];
  logic [SBW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           vld_in;
    logic [CW-1:0]  rem_in;
    logic [QW-1:0]  quo_in;
    logic [DW-1:0]  den_in;
    logic [SBW-1:0] side_in;
    logic [CW-1:0]  dsh;
    logic           ge;
    logic [CW-1:0]  rem_nxt;
    logic [QW-1:0]  quo_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = CW'(in_num);
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign dsh = CW'(den_in) << (QW - 1 - k);
    assign ge  = (rem_in >= dsh);

    always_comb begin
      rem_nxt = ge ? (rem_in - dsh) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[QW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      den_r[k]  <= den_in;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

[design/csvs_map.sv]
// ----------------------------------------------------------------------------
// csvs_map
// Maps a time sample onto the interval: forms a = 2t - start - end and the
// span, runs the exact range test and builds the numerator for x.
// ----------------------------------------------------------------------------
module csvs_map import csvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] in_time,
  input  logic signed [31:0] cfg_start,
  input  logic signed [31:0] cfg_end,
  output logic               out_vld,
  output logic [61:0]        out_num,
  output logic [32:0]        out_den,
  output logic               out_neg,
  output logic               out_err
);

  logic               a_vld_r;
  logic signed [33:0] a_r;
  logic signed [32:0] span_r;
  logic signed [33:0] a_nxt;
  logic signed [32:0] span_nxt;

  logic               m_vld_r;
  logic [61:0]        num_r;
  logic [32:0]        den_r;
  logic               neg_r;
  logic               err_r;
  logic [33:0]        amag;
  logic [32:0]        smag;
  logic [61:0]        num_nxt;
  logic               err_nxt;

  always_comb begin
    a_nxt    = (34'(in_time) <<< 1) - 34'(cfg_start) - 34'(cfg_end);
    span_nxt = 33'(cfg_end) - 33'(cfg_start);
  end

  always_comb begin
    amag    = a_r[33] ? 34'(-a_r) : 34'(a_r);
    smag    = span_r[32] ? 33'(-span_r) : 33'(span_r);
    // |x| >= 1.001 tested without a division
    err_nxt = (smag == '0) || ((44'(amag) * 44'd1000) >= (44'(smag) * 44'd1001));
    num_nxt = (62'(amag) << 28) + 62'(smag >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      m_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    span_r <= span_nxt;
    num_r  <= num_nxt;
    den_r  <= smag;
    neg_r  <= a_r[33] ^ span_r[32];
    err_r  <= err_nxt;
  end

  assign out_vld = m_vld_r;
  assign out_num = num_r;
  assign out_den = den_r;
  assign out_neg = neg_r;
  assign out_err = err_r;

endmodule

[design/csvs_step.sv]
// ----------------------------------------------------------------------------
// csvs_step
// One recurrence step of order ORDER: next T and U terms, adds the value
// and slope contributions. Three register stages.
// ----------------------------------------------------------------------------
module csvs_step import csvs_pkg::*; #(
  parameter int ORDER = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  poly_bus_t          in_bus,
  input  logic signed [31:0] coef,
  output logic               out_vld,
  output poly_bus_t          out_bus
);

  logic                 a_vld_r;
  poly_bus_t            a_bus_r;
  poly_bus_t            a_bus_nxt;
  logic signed [SW-1:0] pt_r;
  logic signed [SW-1:0] pu_r;
  logic signed [SW-1:0] pd_r;
  logic signed [SW-1:0] pt_nxt;
  logic signed [SW-1:0] pu_nxt;
  logic signed [SW-1:0] pd_nxt;

  logic                 b_vld_r;
  poly_bus_t            b_bus_r;
  poly_bus_t            b_bus_nxt;

  logic                 c_vld_r;
  poly_bus_t            c_bus_r;
  poly_bus_t            c_bus_nxt;

  // stage a: fold in the pending value term, form the products
  always_comb begin
    a_bus_nxt   = in_bus;
    a_bus_nxt.y = in_bus.y + rnd_shr(in_bus.py, 6);
    pt_nxt      = in_bus.x * in_bus.tc;
    pu_nxt      = in_bus.x * in_bus.uc;
    pd_nxt      = coef * in_bus.uc;
  end

  // stage b: advance both recurrences, add the slope term
  always_comb begin
    b_bus_nxt    = a_bus_r;
    b_bus_nxt.tp = a_bus_r.tc;
    b_bus_nxt.tc = PW'(rnd_shr(pt_r, 27) - a_bus_r.tp);
    b_bus_nxt.up = a_bus_r.uc;
    b_bus_nxt.uc = PW'(rnd_shr(pu_r, 27) - a_bus_r.up);
    b_bus_nxt.d  = a_bus_r.d + rnd_shr(pd_r, 6) * $signed(64'(ORDER));
  end

  // stage c: value product on the new T term
  always_comb begin
    c_bus_nxt    = b_bus_r;
    c_bus_nxt.py = coef * b_bus_r.tc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_bus_r <= a_bus_nxt;
    pt_r    <= pt_nxt;
    pu_r    <= pu_nxt;
    pd_r    <= pd_nxt;
    b_bus_r <= b_bus_nxt;
    c_bus_r <= c_bus_nxt;
  end

  assign out_vld = c_vld_r;
  assign out_bus = c_bus_r;

endmodule

[design/csvs_poly.sv]
// ----------------------------------------------------------------------------
// csvs_poly
// Signs the mapped x, seeds the recurrences and chains NUM_TERMS-2 steps,
// then folds in the last value term.
// ----------------------------------------------------------------------------
module csvs_poly import csvs_pkg::*; #(
  parameter int NUM_TERMS = NUM_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [DIV1_QW-1:0] in_quo,
  input  logic               in_neg,
  input  logic               in_err,
  input  logic signed [31:0] coef [MAX_TERMS],
  output logic               out_vld,
  output logic signed [SW-1:0] out_y,
  output logic signed [SW-1:0] out_d,
  output logic               out_err
);

  logic                 x_vld_r;
  logic signed [XW-1:0] x_r;
  logic                 x_err_r;
  logic signed [XW-1:0] x_nxt;

  logic                 i_vld_r;
  poly_bus_t            i_bus_r;
  poly_bus_t            i_bus_nxt;

  logic                 chain_vld [NUM_TERMS-1];
  poly_bus_t            chain_bus [NUM_TERMS-1];

  logic                 f_vld_r;
  logic signed [SW-1:0] f_y_r;
  logic signed [SW-1:0] f_d_r;
  logic                 f_err_r;

  always_comb begin
    x_nxt = in_neg ? -$signed(XW'(in_quo)) : $signed(XW'(in_quo));
  end

  // T0 = U0 = 1, T1 = x, U1 = 2x
  always_comb begin
    i_bus_nxt.x   = x_r;
    i_bus_nxt.tp  = ONE_Q28;
    i_bus_nxt.tc  = PW'(x_r);
    i_bus_nxt.up  = ONE_Q28;
    i_bus_nxt.uc  = PW'(x_r) <<< 1;
    i_bus_nxt.y   = SW'(coef[0]) <<< 22;
    i_bus_nxt.py  = coef[1] * x_r;
    i_bus_nxt.d   = SW'(coef[1]) <<< 22;
    i_bus_nxt.err = x_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
    end else begin
      x_vld_r <= in_vld;
      i_vld_r <= x_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    x_err_r <= in_err;
    i_bus_r <= i_bus_nxt;
  end

  assign chain_vld[0] = i_vld_r;
  assign chain_bus[0] = i_bus_r;

  for (genvar i = 2; i < NUM_TERMS; i++) begin : g_step
    csvs_step #(.ORDER(i)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (chain_vld[i-2]),
      .in_bus  (chain_bus[i-2]),
      .coef    (coef[i]),
      .out_vld (chain_vld[i-1]),
      .out_bus (chain_bus[i-1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= chain_vld[NUM_TERMS-2];
    end
  end

  always_ff @(posedge clk) begin
    f_y_r   <= chain_bus[NUM_TERMS-2].y + rnd_shr(chain_bus[NUM_TERMS-2].py, 6);
    f_d_r   <= chain_bus[NUM_TERMS-2].d;
    f_err_r <= chain_bus[NUM_TERMS-2].err;
  end

  assign out_vld = f_vld_r;
  assign out_y   = f_y_r;
  assign out_d   = f_d_r;
  assign out_err = f_err_r;

endmodule

[design/chebyshev_series_value_and_slope_top.sv]
// ----------------------------------------------------------------------------
// chebyshev_series_value_and_slope_top
// Chebyshev series value and time derivative over a configured interval,
// fully pipelined.
//
//  channel   ports                                   direction
//  input     start, busy, in_time_in                 start/data in, busy out
//  result    out_strobe, out_value, out_slope,       out, one-cycle strobe
//            out_range_error
//  config    psel, penable, pwrite, paddr, pwdata,   apb slave, pready high
//            prdata, pready
//
// one beat is taken every cycle; busy stays low
// the path runs through the x divider (30 stages), three stages per
// recurrence step and the slope divider (33 stages)
// synchronous reset empties the pipeline; no clearing pass
// results are not back-pressured: each appears for a single cycle
// ----------------------------------------------------------------------------
module chebyshev_series_value_and_slope_top import csvs_pkg::*; #(
  parameter int NUM_TERMS = NUM_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_time_in,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_slope,
  output logic               out_range_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [31:0] start_time_r;
  logic signed [31:0] end_time_r;
  logic signed [31:0] coef_r [MAX_TERMS];
  cfg_reg_t           reg_idx;
  logic               cfg_wr;

  logic signed [32:0] span;
  logic [32:0]        smag;

  logic               m_vld;
  logic [61:0]        m_num;
  logic [32:0]        m_den;
  logic               m_neg;
  logic               m_err;

  logic               q1_vld;
  logic [DIV1_QW-1:0] q1_quo;
  logic [1:0]         q1_side;

  logic               p_vld;
  logic signed [SW-1:0] p_y;
  logic signed [SW-1:0] p_d;
  logic               p_err;

  logic               f_vld_r;
  logic [51:0]        f_num_r;
  logic               f_neg_r;
  logic               f_err_r;
  logic signed [31:0] f_val_r;
  logic [63:0]        dmag;
  logic [64:0]        dsum;
  logic               ovf;

  logic               q2_vld;
  logic [DIV2_QW-1:0] q2_quo;
  logic [34:0]        q2_side;

  logic               o_vld_r;
  logic signed [31:0] o_val_r;
  logic signed [31:0] o_slope_r;
  logic               o_err_r;
  logic signed [31:0] slope_nxt;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= START_RST;
      end_time_r   <= END_RST;
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef_r[i] <= COEF_RST;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START_TIME: start_time_r <= pwdata;
        REG_END_TIME:   end_time_r   <= pwdata;
        REG_COEF_0:     coef_r[0]    <= pwdata;
        REG_COEF_1:     coef_r[1]    <= pwdata;
        REG_COEF_2:     coef_r[2]    <= pwdata;
        REG_COEF_3:     coef_r[3]    <= pwdata;
        REG_COEF_4:     coef_r[4]    <= pwdata;
        REG_COEF_5:     coef_r[5]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_TIME: prdata = start_time_r;
      REG_END_TIME:   prdata = end_time_r;
      REG_COEF_0:     prdata = coef_r[0];
      REG_COEF_1:     prdata = coef_r[1];
      REG_COEF_2:     prdata = coef_r[2];
      REG_COEF_3:     prdata = coef_r[3];
      REG_COEF_4:     prdata = coef_r[4];
      REG_COEF_5:     prdata = coef_r[5];
      default:        prdata = '0;
    endcase
  end

  // span must only change while idle; the block itself does not enforce this
  always_comb begin
    span = 33'(end_time_r) - 33'(start_time_r);
    smag = span[32] ? 33'(-span) : 33'(span);
  end

  // ---------------- mapping and x division ----------------
  csvs_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .in_time   (in_time_in),
    .cfg_start (start_time_r),
    .cfg_end   (end_time_r),
    .out_vld   (m_vld),
    .out_num   (m_num),
    .out_den   (m_den),
    .out_neg   (m_neg),
    .out_err   (m_err)
  );

  csvs_div #(.NW(62), .DW(33), .QW(DIV1_QW), .SBW(2)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m_vld),
    .in_num   (m_num),
    .in_den   (m_den),
    .in_side  ({m_neg, m_err}),
    .out_vld  (q1_vld),
    .out_quo  (q1_quo),
    .out_side (q1_side)
  );

  // ---------------- series ----------------
  csvs_poly #(.NUM_TERMS(NUM_TERMS)) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (q1_vld),
    .in_quo  (q1_quo),
    .in_neg  (q1_side[1]),
    .in_err  (q1_side[0]),
    .coef    (coef_r),
    .out_vld (p_vld),
    .out_y   (p_y),
    .out_d   (p_d),
    .out_err (p_err)
  );

  // ---------------- slope division ----------------
  // rounding offset added before dropping the 2^13 factor of the divisor
  always_comb begin
    dmag = p_d[63] ? 64'(-p_d) : 64'(p_d);
    dsum = 65'(dmag) + (65'(smag) << 12);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    f_num_r <= dsum[64:13];
    f_neg_r <= p_d[63] ^ span[32];
    f_err_r <= p_err;
    f_val_r <= sat32(rnd_shr(p_y, 30));
  end

  // quotient of 2^33 or more saturates anyway
  assign ovf = ({14'b0, f_num_r[51:33]} >= smag);

  csvs_div #(.NW(52), .DW(33), .QW(DIV2_QW), .SBW(35)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld_r),
    .in_num   (f_num_r),
    .in_den   (smag),
    .in_side  ({ovf, f_neg_r, f_err_r, f_val_r}),
    .out_vld  (q2_vld),
    .out_quo  (q2_quo),
    .out_side (q2_side)
  );

  // ---------------- result ----------------
  always_comb begin
    if (q2_side[33]) begin
      if (q2_side[34] || (q2_quo > 33'h0_8000_0000)) begin
        slope_nxt = 32'sh8000_0000;
      end else begin
        slope_nxt = -$signed(q2_quo[31:0]);
      end
    end else begin
      if (q2_side[34] || (q2_quo > 33'h0_7fff_ffff)) begin
        slope_nxt = 32'sh7fff_ffff;
      end else begin
        slope_nxt = $signed(q2_quo[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= q2_vld;
    end
  end

  always_ff @(posedge clk) begin
    o_err_r   <= q2_side[32];
    o_val_r   <= q2_side[32] ? 32'sd0 : $signed(q2_side[31:0]);
    o_slope_r <= q2_side[32] ? 32'sd0 : slope_nxt;
  end

  assign out_strobe      = o_vld_r;
  assign out_value       = o_val_r;
  assign out_slope       = o_slope_r;
  assign out_range_error = o_err_r;

endmodule

[design/csvs_chk.sv]
// ----------------------------------------------------------------------------
// csvs_chk
// Port-level checks for the Chebyshev series pipeline, bound to the top.
// ----------------------------------------------------------------------------
module csvs_chk import csvs_pkg::*; #(
  parameter int NUM_TERMS = NUM_TERMS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [31:0] out_value,
  input logic signed [31:0] out_slope,
  input logic               out_range_error
);

  localparam int LAT = pipe_latency(NUM_TERMS);

  // every accepted beat comes out after the fixed latency
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted beat produced no result");

  // no result without a beat accepted the fixed latency earlier
  a_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without matching input beat");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_error) |-> (out_value == 32'sd0 && out_slope == 32'sd0))
    else $error("range error with non-zero outputs");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

bind chebyshev_series_value_and_slope_top csvs_chk #(.NUM_TERMS(NUM_TERMS)) u_chk (.*);
